/* rtl/core/fgq_pkg.sv */
// fgq_pkg: constants and types shared by the float32 grid quantiser
// no dependencies
`timescale 1ns / 1ps
package fgq_pkg;
  localparam logic [6:0]  ScaleReset = 7'd15;
  localparam logic [31:0] QnanBits   = 32'h7FC0_0000;
  localparam logic [7:0]  ExpMax     = 8'hFF;
  localparam logic [8:0]  BigExpInf  = 9'd255;
  localparam logic [8:0]  BigExpOnGrid = 9'd150;
  localparam logic [8:0]  MaxShift   = 9'd24;

  // decoded fields of the registered input word
  typedef struct packed {
    logic        sign;
    logic [7:0]  expo;
    logic [22:0] mant;
    logic        last;
  } fgq_word_t;
endpackage

/* rtl/core/float32_grid_quantize_canonicalize_unit.sv */
// float32_grid_quantize_canonicalize_unit: top level of the grid quantiser
// depends on fgq_pkg and fgq_round
// start passes the input register and then the result register before strobe
// throughput: one transaction every cycle, busy is never raised
// reset: asynchronous active low, clears valid flags and sets scale to 15
// the receiver cannot stall, each result is shown for exactly one cycle
`timescale 1ns / 1ps
module float32_grid_quantize_canonicalize_unit import fgq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic [31:0] value_bits_i,
  input  logic        last_in_i,
  output logic        strobe,
  output logic [31:0] result_bits_o,
  output logic        last_out_o
);
  logic [6:0]  scale_q;
  logic        in_vld_q;
  fgq_word_t   in_q;
  logic        out_vld_q;
  logic [31:0] res_q;
  logic        last_q;
  logic [31:0] res_d;

  // never stalls, one word per cycle
  assign busy = 1'b0;

  // grid exponent register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // input and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start;
      out_vld_q <= in_vld_q;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= '{sign: value_bits_i[31], expo: value_bits_i[30:23],
                mant: value_bits_i[22:0], last: last_in_i};
    end
    if (in_vld_q) begin
      res_q  <= res_d;
      last_q <= in_q.last;
    end
  end

  fgq_round u_round (
    .word_i  (in_q),
    .scale_i (scale_q),
    .result_o(res_d)
  );

  assign strobe        = out_vld_q;
  assign result_bits_o = res_q;
  assign last_out_o    = last_q;

`ifndef ASSERT_OFF
  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##1 strobe) else $error("strobe missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(start, 2)) else $error("spurious strobe");
  a_last_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##1 (last_out_o == $past(last_in_i, 2))) else $error("last mismatch");
`endif
endmodule

/* rtl/core/fgq_round.sv */
// fgq_round: combinational quantise / canonicalise of one binary32 word
// depends on fgq_pkg
`timescale 1ns / 1ps
module fgq_round import fgq_pkg::*; (
  input  fgq_word_t   word_i,
  input  logic [6:0]  scale_i,
  output logic [31:0] result_o
);
  logic [8:0]  big_e;
  logic [8:0]  sh9;
  logic [4:0]  sh;
  logic [24:0] sum;
  logic [24:0] r;
  logic [24:0] n;
  logic [24:0] half;

  always_comb begin
    big_e = {1'b0, word_i.expo} + {2'b0, scale_i};
    sh9   = BigExpOnGrid - big_e;
    sh    = sh9[4:0];
    half  = 25'd1 << (sh - 5'd1);
    sum   = {2'b01, word_i.mant} + half;
    r     = sum >> sh;
    n     = r << sh;
    if (word_i.expo == 8'd0) begin
      result_o = 32'd0;
    end else if (word_i.expo == ExpMax) begin
      result_o = (word_i.mant != 23'd0) ? QnanBits : {word_i.sign, ExpMax, 23'd0};
    end else if (big_e >= BigExpInf) begin
      result_o = {word_i.sign, ExpMax, 23'd0};
    end else if (big_e >= BigExpOnGrid) begin
      result_o = {word_i.sign, word_i.expo, word_i.mant};
    end else if (sh9 > MaxShift) begin
      result_o = {word_i.sign, 31'd0};
    end else if (n[24]) begin
      // rounding carried out of the mantissa
      result_o = {word_i.sign, word_i.expo + 8'd1, 23'd0};
    end else begin
      result_o = {word_i.sign, word_i.expo, n[22:0]};
    end
  end
endmodule
